[rtl/efts_pkg.sv]
// shared types and constants for the elevator target floor selector
package efts_pkg;

    localparam int MAX_FLOORS = 9;
    localparam int FLOOR_W    = 4;
    localparam int DIR_W      = 2;
    localparam int HEAD_W     = 5;
    localparam int MOTION_W   = 2;

    localparam logic [DIR_W-1:0] DIR_IDLE = 2'd0;
    localparam logic [DIR_W-1:0] DIR_UP   = 2'd1;
    localparam logic [DIR_W-1:0] DIR_DOWN = 2'd2;

    localparam logic [MOTION_W-1:0] MOTION_IDLE = 2'd0;
    localparam logic [MOTION_W-1:0] MOTION_UP   = 2'd1;
    localparam logic [MOTION_W-1:0] MOTION_DOWN = 2'd2;
    localparam logic [MOTION_W-1:0] MOTION_OPEN = 2'd3;

    localparam logic MODE_QUEUE       = 1'b0;
    localparam logic MODE_DIRECTIONAL = 1'b1;

    // request codes step by ten: plain floor, up call, down call
    localparam logic [HEAD_W-1:0] CODE_STEP_1 = 5'd10;
    localparam logic [HEAD_W-1:0] CODE_STEP_2 = 5'd20;
    localparam logic [HEAD_W-1:0] CODE_STEP_3 = 5'd30;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 8;

    typedef struct packed {
        logic [MAX_FLOORS-1:0] car_calls;
        logic [MAX_FLOORS-1:0] up_calls;
        logic [MAX_FLOORS-1:0] down_calls;
        logic [FLOOR_W-1:0]    current_floor;
        logic [DIR_W-1:0]      travel_direction;
        logic [HEAD_W-1:0]     queue_head;
    } request_t;

    typedef struct packed {
        logic [FLOOR_W-1:0]  target_floor;
        logic [MOTION_W-1:0] next_motion;
    } result_t;

endpackage

[rtl/elevator_target_floor_select.sv]
// Elevator target floor selector. Each transfer on the s_ side carries the pending car, up and
// down call bitmaps, the current floor, the direction of travel and the queue head code; one
// transfer on the m_ side returns the next target floor (0 when nothing pends) and the next
// motion. A request is held in an input register, in directional mode the selection runs as
// one short priority network over the floor bits, and the result lands in an output register,
// so one request is taken every cycle while m_tready stays high; each result passes the
// input and then the output register. dispatch_mode (reset 1, directional) is written over
// the cfg channel while the block is idle; the user must keep to this, it is not enforced.
module elevator_target_floor_select #(
    parameter int FLOORS = 9
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // car_calls[8:0], up_calls[17:9], down_calls[26:18], current_floor[30:27],
    // travel_direction[32:31], queue_head[37:33], zero fill
    input  logic [efts_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // target_floor[3:0], next_motion[5:4], zero fill
    output logic [efts_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic                             cfg_data
);

    localparam int NF = efts_pkg::MAX_FLOORS;

    logic               dispatch_mode_reg;
    logic               in_valid_reg;
    efts_pkg::request_t req_reg;
    efts_pkg::request_t req_next;
    efts_pkg::result_t  res_next;
    efts_pkg::result_t  res_reg;
    logic               m_valid_reg;
    logic               out_free;
    logic               advance;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dispatch_mode_reg <= efts_pkg::MODE_DIRECTIONAL;
        end else if (cfg_valid) begin
            dispatch_mode_reg <= cfg_data;
        end
    end

    assign out_free = !m_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    always_comb begin
        req_next.car_calls        = s_tdata[NF-1:0];
        req_next.up_calls         = s_tdata[2*NF-1:NF];
        req_next.down_calls       = s_tdata[3*NF-1:2*NF];
        req_next.current_floor    = s_tdata[30:27];
        req_next.travel_direction = s_tdata[32:31];
        req_next.queue_head       = s_tdata[37:33];
    end

    // input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            req_reg <= req_next;
        end
    end

    efts_select #(
        .FLOORS(FLOORS)
    ) u_select (
        .req          (req_reg),
        .dispatch_mode(dispatch_mode_reg),
        .res          (res_next)
    );

    // output stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, res_reg.next_motion, res_reg.target_floor};

endmodule

[rtl/efts_select.sv]
// combinational target floor and motion selection for one request
module efts_select #(
    parameter int FLOORS = 9
) (
    input  efts_pkg::request_t req,
    input  logic               dispatch_mode,
    output efts_pkg::result_t  res
);

    localparam int NF = efts_pkg::MAX_FLOORS;
    localparam int FW = efts_pkg::FLOOR_W;

    function automatic logic [FW-1:0] lowest_floor(input logic [NF-1:0] m);
        logic [FW-1:0] r;
        r = '0;
        for (int i = NF - 1; i >= 0; i--) begin
            if (m[i]) begin
                r = FW'(i + 1);
            end
        end
        return r;
    endfunction

    function automatic logic [FW-1:0] highest_floor(input logic [NF-1:0] m);
        logic [FW-1:0] r;
        r = '0;
        for (int i = 0; i < NF; i++) begin
            if (m[i]) begin
                r = FW'(i + 1);
            end
        end
        return r;
    endfunction

    logic [NF-1:0] above_mask;
    logic [NF-1:0] below_mask;
    logic [NF-1:0] at_mask;
    logic [NF-1:0] car;
    logic [NF-1:0] up;
    logic [NF-1:0] down;
    logic [FW-1:0] f;
    logic [FW-1:0] dir_target;
    logic [FW-1:0] queue_target;
    logic [FW-1:0] target;
    logic [FW-1:0] c1;
    logic [FW-1:0] c2;
    logic [FW-1:0] c3;
    logic [FW-1:0] c4;
    logic [efts_pkg::HEAD_W-1:0] head;

    assign f    = req.current_floor;
    assign head = req.queue_head;

    always_comb begin
        for (int i = 0; i < NF; i++) begin
            above_mask[i] = (i < FLOORS) && (FW'(i + 1) > f);
            below_mask[i] = (i < FLOORS) && (FW'(i + 1) < f);
            at_mask[i]    = (i < FLOORS) && (FW'(i + 1) == f);
        end
    end

    assign car  = req.car_calls;
    assign up   = req.up_calls;
    assign down = req.down_calls;

    always_comb begin
        if (req.travel_direction != efts_pkg::DIR_DOWN) begin
            c1 = lowest_floor((car | up) & above_mask);
            c2 = highest_floor((car | down) & above_mask);
            c3 = highest_floor((car | down) & below_mask);
            c4 = lowest_floor(up & (below_mask | at_mask));
        end else begin
            c1 = highest_floor((car | down) & below_mask);
            c2 = lowest_floor((car | up) & below_mask);
            c3 = lowest_floor((car | up) & above_mask);
            c4 = highest_floor(down & (above_mask | at_mask));
        end
        if (c1 != '0) begin
            dir_target = c1;
        end else if (c2 != '0) begin
            dir_target = c2;
        end else if (c3 != '0) begin
            dir_target = c3;
        end else begin
            dir_target = c4;
        end
    end

    // head code modulo ten
    always_comb begin
        if (head >= efts_pkg::CODE_STEP_3) begin
            queue_target = FW'(head - efts_pkg::CODE_STEP_3);
        end else if (head >= efts_pkg::CODE_STEP_2) begin
            queue_target = FW'(head - efts_pkg::CODE_STEP_2);
        end else if (head >= efts_pkg::CODE_STEP_1) begin
            queue_target = FW'(head - efts_pkg::CODE_STEP_1);
        end else begin
            queue_target = FW'(head);
        end
    end

    assign target = (dispatch_mode == efts_pkg::MODE_QUEUE) ? queue_target : dir_target;

    always_comb begin
        res.target_floor = target;
        if (target == '0) begin
            res.next_motion = efts_pkg::MOTION_IDLE;
        end else if (target > f) begin
            res.next_motion = efts_pkg::MOTION_UP;
        end else if (target < f) begin
            res.next_motion = efts_pkg::MOTION_DOWN;
        end else begin
            res.next_motion = efts_pkg::MOTION_OPEN;
        end
    end

endmodule

[tb/target_floor_checker.sv]
// checker for the elevator target floor selector: predicts each dispatch and compares results
`timescale 1ns / 100ps

module target_floor_checker
    import efts_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic                 cfg_data,
    output int                   mismatches,
    output int                   outstanding
);

    logic     dispatch_mode = MODE_DIRECTIONAL;
    result_t  expected_targets[$];
    int       fail_count = 0;
    int       waiting = 0;
    request_t rq;
    result_t  got;
    result_t  want;

    assign mismatches  = fail_count;
    assign outstanding = waiting;

    function automatic result_t predict_target(request_t q, logic mode);
        logic [MAX_FLOORS-1:0] car_up;
        logic [MAX_FLOORS-1:0] car_down;
        int f;
        int t;
        int g;
        result_t r;
        car_up   = q.car_calls | q.up_calls;
        car_down = q.car_calls | q.down_calls;
        f = q.current_floor;
        t = 0;
        if (mode == MODE_QUEUE) begin
            t = q.queue_head % 10;
        end else if (q.travel_direction != DIR_DOWN) begin
            for (g = f + 1; g <= MAX_FLOORS && t == 0; g++)
                if (car_up[g-1]) t = g;
            for (g = MAX_FLOORS; g > f && g >= 1 && t == 0; g--)
                if (car_down[g-1]) t = g;
            for (g = (f - 1 < MAX_FLOORS) ? f - 1 : MAX_FLOORS; g >= 1 && t == 0; g--)
                if (car_down[g-1]) t = g;
            for (g = 1; g <= f && g <= MAX_FLOORS && t == 0; g++)
                if (q.up_calls[g-1]) t = g;
        end else begin
            for (g = (f - 1 < MAX_FLOORS) ? f - 1 : MAX_FLOORS; g >= 1 && t == 0; g--)
                if (car_down[g-1]) t = g;
            for (g = 1; g < f && g <= MAX_FLOORS && t == 0; g++)
                if (car_up[g-1]) t = g;
            for (g = f + 1; g <= MAX_FLOORS && t == 0; g++)
                if (car_up[g-1]) t = g;
            for (g = MAX_FLOORS; g >= f && g >= 1 && t == 0; g--)
                if (q.down_calls[g-1]) t = g;
        end
        r.target_floor = t[FLOOR_W-1:0];
        if (t == 0)
            r.next_motion = MOTION_IDLE;
        else if (t > f)
            r.next_motion = MOTION_UP;
        else if (t < f)
            r.next_motion = MOTION_DOWN;
        else
            r.next_motion = MOTION_OPEN;
        return r;
    endfunction

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("[%0t] %s", $realtime, msg);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            dispatch_mode = MODE_DIRECTIONAL;
            expected_targets.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got.target_floor = m_tdata[3:0];
                got.next_motion  = m_tdata[5:4];
                if (expected_targets.size() == 0) begin
                    note_failure($sformatf("unexpected result transfer: target %0d motion %0d",
                        got.target_floor, got.next_motion));
                end else begin
                    want = expected_targets.pop_front();
                    if (got.target_floor != want.target_floor ||
                        got.next_motion != want.next_motion)
                        note_failure($sformatf(
                            "target %0d motion %0d, expected target %0d motion %0d",
                            got.target_floor, got.next_motion,
                            want.target_floor, want.next_motion));
                end
            end
            if (s_tvalid && s_tready) begin
                rq.car_calls        = s_tdata[8:0];
                rq.up_calls         = s_tdata[17:9];
                rq.down_calls       = s_tdata[26:18];
                rq.current_floor    = s_tdata[30:27];
                rq.travel_direction = s_tdata[32:31];
                rq.queue_head       = s_tdata[37:33];
                expected_targets.push_back(predict_target(rq, dispatch_mode));
            end
            if (cfg_valid && cfg_ready)
                dispatch_mode = cfg_data;
        end
        waiting = expected_targets.size();
    end

endmodule

[tb/elevator_target_floor_select_test.sv]
// testbench top for the elevator target floor selector: stimulus, flow control and verdict
`timescale 1ns / 100ps

module elevator_target_floor_select_test;

    import efts_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic                 cfg_data = 1'b0;

    int mismatches;
    int outstanding;
    int sent_count = 0;
    int cycle_count = 0;
    bit steady_flow = 1'b0;

    elevator_target_floor_select #(
        .FLOORS(MAX_FLOORS)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    target_floor_checker checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .outstanding(outstanding)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic int pause_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        else if (r < 93)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic logic [MAX_FLOORS-1:0] floor_bit(input int f);
        return 9'd1 << (f - 1);
    endfunction

    function automatic logic [S_TDATA_W-1:0] pack_request(
        input logic [MAX_FLOORS-1:0] car,
        input logic [MAX_FLOORS-1:0] up,
        input logic [MAX_FLOORS-1:0] down,
        input logic [FLOOR_W-1:0]    floor_now,
        input logic [DIR_W-1:0]      dir,
        input logic [HEAD_W-1:0]     head
    );
        return {2'b00, head, dir, floor_now, down, up, car};
    endfunction

    function automatic logic [MAX_FLOORS-1:0] random_calls();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return floor_bit($urandom_range(1, MAX_FLOORS));
            2:       return MAX_FLOORS'($urandom & $urandom);
            default: return MAX_FLOORS'($urandom);
        endcase
    endfunction

    task automatic offer_request(input logic [S_TDATA_W-1:0] word);
        int gap;
        gap = steady_flow ? 0 : pause_length();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent_count++;
    endtask

    task automatic drain_and_set_mode(input logic mode);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        wait (outstanding == 0);
        repeat (4) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= mode;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_requests(input int count, input int steady_from, input int steady_to);
        logic [FLOOR_W-1:0] floor_now;
        int i;
        for (i = 0; i < count; i++) begin
            steady_flow = (i >= steady_from && i < steady_to);
            if ($urandom_range(0, 9) < 8)
                floor_now = FLOOR_W'($urandom_range(1, MAX_FLOORS));
            else
                floor_now = FLOOR_W'($urandom_range(0, 15));
            offer_request(pack_request(random_calls(), random_calls(), random_calls(),
                floor_now, DIR_W'($urandom_range(0, 3)), HEAD_W'($urandom_range(0, 31))));
        end
        steady_flow = 1'b0;
    endtask

    // sink side: random stalls, one long hold-off so the pipeline backs up
    initial begin
        int  gap;
        bit  held_off;
        held_off = 1'b0;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (!held_off && sent_count >= 300) begin
                held_off = 1'b1;
                m_tready <= 1'b0;
                repeat (400) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            gap = steady_flow ? 0 : pause_length();
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    end

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directional mode out of reset
        offer_request(pack_request('0, '0, '0, 4'd1, DIR_IDLE, 5'd0));
        offer_request(pack_request('1, '1, '1, 4'd9, DIR_UP, 5'd31));
        offer_request(pack_request('1, '1, '1, 4'd1, DIR_DOWN, 5'd29));
        offer_request(pack_request(floor_bit(7), '0, '0, 4'd3, DIR_UP, 5'd10));
        offer_request(pack_request('0, '0, floor_bit(8) | floor_bit(5), 4'd3, DIR_UP, 5'd20));
        offer_request(pack_request('0, '0, floor_bit(2), 4'd5, DIR_IDLE, 5'd30));
        offer_request(pack_request('0, floor_bit(2) | floor_bit(5), '0, 4'd5, DIR_UP, 5'd1));
        offer_request(pack_request('0, floor_bit(5), '0, 4'd5, DIR_IDLE, 5'd9));
        offer_request(pack_request('0, '0, floor_bit(3), 4'd6, DIR_DOWN, 5'd19));
        offer_request(pack_request('0, floor_bit(2) | floor_bit(4), '0, 4'd6, DIR_DOWN, 5'd0));
        offer_request(pack_request('0, floor_bit(8), '0, 4'd6, DIR_DOWN, 5'd15));
        offer_request(pack_request('0, '0, floor_bit(6), 4'd6, DIR_DOWN, 5'd25));
        offer_request(pack_request('0, '0, floor_bit(7) | floor_bit(9), 4'd6, DIR_DOWN, 5'd5));
        offer_request(pack_request(floor_bit(1), '0, '0, 4'd5, 2'd3, 5'd11));
        offer_request(pack_request('1, '0, '0, 4'd0, DIR_UP, 5'd21));
        offer_request(pack_request('0, '0, '1, 4'd15, DIR_DOWN, 5'd31));
        offer_request(pack_request('0, floor_bit(3), '0, 4'd0, DIR_DOWN, 5'd2));
        offer_request(pack_request('0, floor_bit(4), '0, 4'd12, DIR_UP, 5'd28));

        // queue mode: plain, up and down codes plus the odd ones
        drain_and_set_mode(MODE_QUEUE);
        offer_request(pack_request('1, '1, '1, 4'd1, DIR_UP, 5'd0));
        offer_request(pack_request('0, '0, '0, 4'd1, DIR_IDLE, 5'd9));
        offer_request(pack_request('0, '0, '0, 4'd5, DIR_DOWN, 5'd10));
        offer_request(pack_request('0, '0, '0, 4'd5, DIR_UP, 5'd15));
        offer_request(pack_request('0, '0, '0, 4'd9, DIR_IDLE, 5'd20));
        offer_request(pack_request('0, '0, '0, 4'd9, DIR_DOWN, 5'd29));
        offer_request(pack_request('0, '0, '0, 4'd3, 2'd3, 5'd30));
        offer_request(pack_request('0, '0, '0, 4'd1, DIR_UP, 5'd31));

        drain_and_set_mode(MODE_DIRECTIONAL);
        random_requests(400, 150, 250);
        drain_and_set_mode(MODE_QUEUE);
        random_requests(200, 0, 0);
        drain_and_set_mode(MODE_DIRECTIONAL);
        random_requests(400, 100, 200);
        drain_and_set_mode(MODE_QUEUE);
        random_requests(200, 50, 100);

        s_tvalid <= 1'b0;
        @(posedge aclk);
        wait (outstanding == 0);
        repeat (8) @(posedge aclk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

[elevator_target_floor_select.f]
rtl/efts_pkg.sv
rtl/efts_select.sv
rtl/elevator_target_floor_select.sv
tb/target_floor_checker.sv
tb/elevator_target_floor_select_test.sv
